// File: rtl/blwbc_pkg.sv
// ----------------------------------------------------------------------------
// blwbc_pkg
// Shared constants, opcodes, controller states and the command and status
// structs between the cache controller and its tag datapath.
// ----------------------------------------------------------------------------
package blwbc_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int SLOT_W   = 6;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic capture;      // latch request, preset flush rank counter
		logic access;       // apply read/write update, load result
		logic flush_emit;   // clear dirty mark of current entry, load result
		logic flush_empty;  // load the empty-flush result
		logic flush_dec;    // step flush rank counter toward most recent
	} ctrl_cmd_t;

	typedef struct packed {
		logic any_dirty;    // some valid entry is dirty
		logic match_dirty;  // entry at the current flush rank is valid and dirty
		logic match_last;   // it is the only dirty entry left
	} ctrl_sts_t;

endpackage

// File: rtl/blwbc_ctrl.sv
// ----------------------------------------------------------------------------
// blwbc_ctrl
// Request sequencer: input and output handshakes, access and flush walk.
// ----------------------------------------------------------------------------
module blwbc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [blwbc_pkg::OP_W-1:0]   opcode,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  blwbc_pkg::ctrl_sts_t         sts,
	output blwbc_pkg::ctrl_cmd_t         cmd
);
	import blwbc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_READ:  state_d = ST_ACCESS;
						OP_WRITE: state_d = ST_ACCESS;
						OP_FLUSH: state_d = ST_FLUSH;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACCESS: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (!sts.any_dirty) begin
					if (out_free)
						state_d = ST_IDLE;
				end else if (sts.match_dirty && sts.match_last && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ACCESS: begin
				cmd.access = out_free;
			end
			ST_FLUSH: begin
				cmd.flush_empty = !sts.any_dirty && out_free;
				cmd.flush_emit  = sts.any_dirty && sts.match_dirty && out_free;
				// skip clean ranks; after an emit, move on unless it was the last
				cmd.flush_dec   = sts.any_dirty &&
				                  (!sts.match_dirty || (out_free && !sts.match_last));
			end
			default: ;
		endcase
	end

	assign load = cmd.access || cmd.flush_emit || cmd.flush_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/blwbc_dpath.sv
// ----------------------------------------------------------------------------
// blwbc_dpath
// Tag store with parallel key match, recency ranks, dirty marks, occupancy
// and the registered result fields.
// ----------------------------------------------------------------------------
module blwbc_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [blwbc_pkg::OP_W-1:0]     opcode,
	input  logic [blwbc_pkg::KEY_W-1:0]    sector_key,
	input  blwbc_pkg::ctrl_cmd_t           cmd,
	output blwbc_pkg::ctrl_sts_t           sts,
	output logic                           hit,
	output logic [blwbc_pkg::SLOT_W-1:0]   slot,
	output logic                           fill_needed,
	output logic                           writeback_needed,
	output logic [blwbc_pkg::KEY_W-1:0]    writeback_key,
	output logic                           last
);
	import blwbc_pkg::*;

	// entry state
	logic [KEY_W-1:0]    key_q   [CAPACITY];
	logic [IDX_W-1:0]    rank_q  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CAPACITY-1:0] dirty_q;
	logic [OCC_W-1:0]    occ_q;

	// request
	logic                is_write_q;
	logic [KEY_W-1:0]    req_key_q;
	logic [IDX_W-1:0]    fcnt_q;

	// result register
	logic                hit_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                fill_q;
	logic                wb_q;
	logic [KEY_W-1:0]    wbkey_q;
	logic                last_q;

	logic [CAPACITY-1:0] hit_vec, evict_vec, fl_vec, vd_vec;
	logic [IDX_W-1:0]    hit_idx, free_idx, evict_idx, fl_idx, sel_idx;
	logic                hit_any, full;
	logic [IDX_W-1:0]    hit_rank;
	logic                acc_wb;
	logic [KEY_W-1:0]    acc_wbkey;

	assign full = (occ_q == OCC_W'(CAPACITY));

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i]   = valid_q[i] && (key_q[i] == req_key_q);
			evict_vec[i] = valid_q[i] && (rank_q[i] == IDX_W'(CAPACITY - 1));
			fl_vec[i]    = valid_q[i] && (rank_q[i] == fcnt_q);
			vd_vec[i]    = valid_q[i] && dirty_q[i];
		end
	end

	// priority encoders, lowest index wins
	always_comb begin
		hit_idx   = '0;
		free_idx  = '0;
		evict_idx = '0;
		fl_idx    = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_vec[i])   hit_idx   = IDX_W'(i);
			if (!valid_q[i])  free_idx  = IDX_W'(i);
			if (evict_vec[i]) evict_idx = IDX_W'(i);
			if (fl_vec[i])    fl_idx    = IDX_W'(i);
		end
	end

	assign hit_any  = |hit_vec;
	assign hit_rank = rank_q[hit_idx];
	assign sel_idx  = hit_any ? hit_idx : (full ? evict_idx : free_idx);

	assign acc_wb    = !hit_any && full && dirty_q[evict_idx];
	assign acc_wbkey = acc_wb ? key_q[evict_idx] : '0;

	assign sts.any_dirty   = |vd_vec;
	assign sts.match_dirty = |(fl_vec & vd_vec);
	assign sts.match_last  = ((vd_vec & ~fl_vec) == '0);

	// control-side entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			occ_q   <= '0;
		end else begin
			if (cmd.access) begin
				valid_q[sel_idx] <= 1'b1;
				if (is_write_q)
					dirty_q[sel_idx] <= 1'b1;
				else if (!hit_any)
					dirty_q[sel_idx] <= 1'b0;
				if (!hit_any && !full)
					occ_q <= occ_q + OCC_W'(1);
			end
			if (cmd.flush_emit)
				dirty_q[fl_idx] <= 1'b0;
		end
	end

	// keys, ranks, request and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_write_q <= (opcode == OP_WRITE);
			req_key_q  <= sector_key;
			fcnt_q     <= IDX_W'(occ_q - OCC_W'(1));
		end
		if (cmd.flush_dec)
			fcnt_q <= fcnt_q - IDX_W'(1);
		if (cmd.access) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (valid_q[i] && (IDX_W'(i) != sel_idx) &&
				    (!hit_any || (rank_q[i] < hit_rank)))
					rank_q[i] <= rank_q[i] + IDX_W'(1);
			end
			rank_q[sel_idx] <= '0;
			key_q[sel_idx]  <= req_key_q;
			hit_q   <= hit_any;
			slot_q  <= SLOT_W'(sel_idx);
			fill_q  <= !hit_any && !is_write_q;
			wb_q    <= acc_wb;
			wbkey_q <= acc_wbkey;
			last_q  <= 1'b1;
		end
		if (cmd.flush_emit) begin
			hit_q   <= 1'b0;
			slot_q  <= SLOT_W'(fl_idx);
			fill_q  <= 1'b0;
			wb_q    <= 1'b1;
			wbkey_q <= key_q[fl_idx];
			last_q  <= sts.match_last;
		end
		if (cmd.flush_empty) begin
			hit_q   <= 1'b0;
			slot_q  <= '0;
			fill_q  <= 1'b0;
			wb_q    <= 1'b0;
			wbkey_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign hit              = hit_q;
	assign slot             = slot_q;
	assign fill_needed      = fill_q;
	assign writeback_needed = wb_q;
	assign writeback_key    = wbkey_q;
	assign last             = last_q;

endmodule

// File: rtl/block_lru_write_back_cache_top.sv
// A read or write request is captured when accepted; its result is registered in
// the access state that follows. A new request is accepted only in the idle state,
// once the previous result has been loaded. A flush is captured, then walks one rank
// per cycle from least recent down to the most recent dirty entry, holding at a dirty
// rank while the output register is full; any result waits while it is full.
// Reset is asynchronous and clears all valid and dirty marks and the occupancy count.
// ----------------------------------------------------------------------------
// block_lru_write_back_cache_top
// Fully associative write-back sector cache tag and LRU replacement engine.
// ----------------------------------------------------------------------------
module block_lru_write_back_cache_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [blwbc_pkg::OP_W-1:0]     opcode,
	input  logic [blwbc_pkg::KEY_W-1:0]    sector_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [blwbc_pkg::SLOT_W-1:0]   slot,
	output logic                           fill_needed,
	output logic                           writeback_needed,
	output logic [blwbc_pkg::KEY_W-1:0]    writeback_key,
	output logic                           last
);
	import blwbc_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	blwbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	blwbc_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.opcode           (opcode),
		.sector_key       (sector_key),
		.cmd              (cmd),
		.sts              (sts),
		.hit              (hit),
		.slot             (slot),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_key    (writeback_key),
		.last             (last)
	);

endmodule

// File: rtl/blwbc_checker.sv
// ----------------------------------------------------------------------------
// blwbc_checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module blwbc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           hit,
	input logic [blwbc_pkg::SLOT_W-1:0]   slot,
	input logic                           fill_needed,
	input logic                           writeback_needed,
	input logic [blwbc_pkg::KEY_W-1:0]    writeback_key,
	input logic                           last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot))
		else $error("result dropped while stalled");

	a_wbkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !writeback_needed |-> writeback_key == '0)
		else $error("write-back key set without write-back");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !fill_needed && !writeback_needed && last)
		else $error("hit result requests fill or write-back");

	// only flush results may be non-final, and those always write back
	a_nonlast_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> writeback_needed && !hit && !fill_needed)
		else $error("non-final result is not a flush write-back");

endmodule

bind block_lru_write_back_cache_top blwbc_checker u_blwbc_checker (.*);

// File: dv/block_lru_write_back_cache_top_tb.sv
// ----------------------------------------------------------------------------
// block_lru_write_back_cache_top_tb
// Self-checking bench for the LRU write-back cache tag engine. A shadow copy
// of the tags, dirty marks and recency order predicts every result. Requests
// come from a directed list, then from random traffic over a small working
// set, write sweeps that overfill the cache, and noise. Both handshakes
// stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module block_lru_write_back_cache_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import blwbc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 300;
	localparam int POOL_SIZE = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [7:0]       gap;
		logic             drain;
	} request_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              fill;
		logic              wb;
		logic [KEY_W-1:0]  wb_key;
		logic              last;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   opcode = '0;
	logic [KEY_W-1:0]  sector_key = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              fill_needed;
	logic              writeback_needed;
	logic [KEY_W-1:0]  writeback_key;
	logic              last;

	// shadow of the cache tag state
	logic [KEY_W-1:0] tag_key [CAPACITY];
	logic             tag_valid [CAPACITY];
	logic             tag_dirty [CAPACITY];
	int               tag_age [CAPACITY];
	int               tag_count;

	request_t pending_q [$];
	outcome_t expected_q [$];
	request_t offered;
	int       n_accepted = 0;
	int       n_requests = 0;
	int       n_errors = 0;
	int       hold_at = 1_000_000;
	logic     hold_off = 1'b0;
	int       stall_pct = 25;
	int       idle_left = 0;
	int       stall_left = 0;

	block_lru_write_back_cache_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.sector_key       (sector_key),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.slot             (slot),
		.fill_needed      (fill_needed),
		.writeback_needed (writeback_needed),
		.writeback_key    (writeback_key),
		.last             (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTED) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
		end
	endtask

	task automatic clear_tags();
		for (int i = 0; i < CAPACITY; i++) begin
			tag_key[i] = '0;
			tag_valid[i] = 1'b0;
			tag_dirty[i] = 1'b0;
			tag_age[i] = 0;
		end
		tag_count = 0;
	endtask

	// make slot s the most recent; valid entries younger than limit age by one
	task automatic make_recent(input int s, input int limit);
		for (int i = 0; i < CAPACITY; i++) begin
			if (tag_valid[i] && i != s && tag_age[i] < limit) begin
				tag_age[i]++;
			end
		end
		tag_age[s] = 0;
	endtask

	task automatic predict_access(input logic is_write, input logic [KEY_W-1:0] key);
		int s;
		int oldest;
		outcome_t o;
		s = -1;
		o = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (s < 0 && tag_valid[i] && tag_key[i] == key) begin
				s = i;
			end
		end
		if (s >= 0) begin
			o.hit = 1'b1;
			make_recent(s, tag_age[s]);
		end else begin
			if (tag_count < CAPACITY) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (s < 0 && !tag_valid[i]) begin
						s = i;
					end
				end
			end
			if (s < 0) begin
				// full: evict the least recent entry
				oldest = 0;
				s = 0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (tag_valid[i] && tag_age[i] >= oldest) begin
						oldest = tag_age[i];
						s = i;
					end
				end
				if (tag_dirty[s]) begin
					o.wb = 1'b1;
					o.wb_key = tag_key[s];
				end
				tag_valid[s] = 1'b0;
				tag_count = CAPACITY - 1;
			end
			make_recent(s, 255);
			tag_valid[s] = 1'b1;
			tag_key[s] = key;
			tag_dirty[s] = 1'b0;
			tag_count++;
		end
		if (is_write) begin
			tag_dirty[s] = 1'b1;
		end
		o.slot = SLOT_W'(s);
		o.fill = !o.hit && !is_write;
		o.last = 1'b1;
		expected_q.push_back(o);
	endtask

	// write back dirty entries from least to most recent
	task automatic predict_flush();
		outcome_t held;
		logic have;
		held = '0;
		have = 1'b0;
		for (int r = tag_count; r > 0; r--) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (tag_valid[i] && tag_age[i] == r - 1 && tag_dirty[i]) begin
					tag_dirty[i] = 1'b0;
					if (have) begin
						expected_q.push_back(held);
					end
					held = '0;
					held.slot = SLOT_W'(i);
					held.wb = 1'b1;
					held.wb_key = tag_key[i];
					have = 1'b1;
				end
			end
		end
		held.last = 1'b1;
		expected_q.push_back(held);
	endtask

	task automatic predict_request(input request_t req);
		case (req.op)
			OP_READ: begin
				predict_access(1'b0, req.key);
			end
			OP_WRITE: begin
				predict_access(1'b1, req.key);
			end
			OP_FLUSH: begin
				predict_flush();
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input int gap_pct, input logic drain);
		request_t req;
		req.op = op;
		req.key = key;
		req.gap = ($urandom_range(0, 99) < gap_pct) ? 8'(gap_len()) : 8'd0;
		req.drain = drain;
		pending_q.push_back(req);
		n_requests++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_READ;
			sector_key <= '0;
			idle_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_request(offered);
				n_accepted++;
			end
			if (!(in_valid && !in_ready)) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0
						&& !(pending_q[0].drain && expected_q.size() != 0)) begin
					offered = pending_q.pop_front();
					in_valid <= 1'b1;
					opcode <= offered.op;
					sector_key <= offered.key;
					idle_left = offered.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result checker
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = expected_q.pop_front();
					check_field("hit", KEY_W'(hit), KEY_W'(want.hit));
					check_field("slot", KEY_W'(slot), KEY_W'(want.slot));
					check_field("fill_needed", KEY_W'(fill_needed), KEY_W'(want.fill));
					check_field("writeback_needed", KEY_W'(writeback_needed),
						KEY_W'(want.wb));
					check_field("writeback_key", writeback_key, want.wb_key);
					check_field("last", KEY_W'(last), KEY_W'(want.last));
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct) begin
					stall_left = gap_len();
				end
			end
		end
	end

	// vary how often the receiver stalls, including stretches with no stalls
	initial begin
		forever begin
			repeat (300) @(posedge clk);
			case ($urandom_range(0, 2))
				0: stall_pct <= 0;
				1: stall_pct <= 15;
				default: stall_pct <= 40;
			endcase
		end
	end

	// one long receiver hold-off while the sender keeps offering
	initial begin
		while (n_accepted < hold_at) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#60_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] pool [POOL_SIZE];
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] key;
		int n_rand;
		int len;
		int kind;
		int pct;
		int r;
		logic drain;
		logic in_window;

		clear_tags();

		// directed: empty flush, extreme keys, hits, write misses, unused opcode
		add_request(OP_FLUSH, 16'h0000, 0, 1'b0);
		add_request(OP_READ, 16'h0000, 0, 1'b0);
		add_request(OP_READ, 16'hFFFF, 0, 1'b0);
		add_request(OP_READ, 16'h0000, 0, 1'b0);
		add_request(OP_WRITE, 16'hFFFF, 0, 1'b0);
		add_request(OP_WRITE, 16'h5555, 0, 1'b0);
		add_request(OP_WRITE, 16'hAAAA, 0, 1'b0);
		add_request(OP_UNUSED, 16'h1234, 0, 1'b0);
		add_request(OP_READ, 16'h1234, 0, 1'b0);
		add_request(OP_FLUSH, 16'hFFFF, 0, 1'b0);
		add_request(OP_FLUSH, 16'h0000, 0, 1'b0);
		add_request(OP_WRITE, 16'h8001, 0, 1'b0);
		add_request(OP_READ, 16'h7FFE, 0, 1'b0);
		add_request(OP_WRITE, 16'h0000, 0, 1'b0);
		add_request(OP_READ, 16'h5555, 0, 1'b0);
		add_request(OP_FLUSH, 16'h1234, 0, 1'b0);
		add_request(OP_UNUSED, 16'hFFFF, 0, 1'b0);
		hold_at = n_requests + 100;

		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			pool[i] = KEY_W'($urandom_range(0, 65535));
		end

		n_rand = 0;
		while (n_rand < RANDOM_REQUESTS) begin
			// keep the sender busy around the receiver hold-off
			in_window = n_rand >= 90 && n_rand < 240;
			r = $urandom_range(0, 2);
			pct = in_window ? 0 : (r == 0 ? 0 : (r == 1 ? 20 : 50));
			drain = (n_rand == 0) || (!in_window && $urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				// working set: hits, misses and evictions
				len = $urandom_range(10, 30);
				for (int j = 0; j < len; j++) begin
					r = $urandom_range(0, 99);
					op = (r < 45) ? OP_READ : (r < 88) ? OP_WRITE
						: (r < 96) ? OP_FLUSH : OP_UNUSED;
					key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
						: KEY_W'($urandom_range(0, 65535));
					add_request(op, key, pct, drain && j == 0);
					if (op != OP_UNUSED) begin
						n_rand++;
					end
				end
			end else if (kind < 8) begin
				// sweep past capacity with fresh keys, then flush
				len = $urandom_range(33, 40);
				for (int j = 0; j < len; j++) begin
					op = ($urandom_range(0, 99) < 80) ? OP_WRITE : OP_READ;
					add_request(op, KEY_W'($urandom_range(0, 65535)), pct, drain && j == 0);
					n_rand++;
				end
				add_request(OP_FLUSH, KEY_W'($urandom_range(0, 65535)), pct, 1'b0);
				n_rand++;
			end else begin
				// noise: any opcode, any key
				len = $urandom_range(3, 8);
				for (int j = 0; j < len; j++) begin
					op = OP_W'($urandom_range(0, 3));
					add_request(op, KEY_W'($urandom_range(0, 65535)), pct, drain && j == 0);
					if (op != OP_UNUSED) begin
						n_rand++;
					end
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_requests) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
